// ----- rtl/sfcs_pkg.sv -----
`default_nettype none

package sfcs_pkg;

   // request function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // table read address select
   localparam logic [1:0] SEL_LO  = 2'd0;
   localparam logic [1:0] SEL_HI  = 2'd1;
   localparam logic [1:0] SEL_MID = 2'd2;

   typedef struct packed {
      logic       write;       // store one table entry
      logic       init;        // capture query value, bounds, clear flags
      logic       reinit;      // restore bounds for the floor pass
      logic [1:0] rd_sel;      // address of the next table read
      logic       lo_mid_inc;  // lo = mid + 1
      logic       lo_mid;      // lo = mid
      logic       hi_mid;      // hi = mid
      logic       hi_mid_dec;  // hi = mid - 1
      logic       ceil_set;    // ceiling found, value from read data
      logic       floor_take;  // floor candidate from read data, no flag
      logic       floor_set;   // floor found, value from read data
      logic       floor_keep;  // floor found, keep candidate
      logic       respond;     // register the result
   } cmd_type;

   typedef struct packed {
      logic empty;      // hi below lo
      logic x_lt_d;     // query below read data
      logic x_eq_d;     // query equals read data
      logic mid_is_lo;  // midpoint equals lo
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/sorted_floor_ceiling_search.sv -----
`default_nettype none

// Channel   Handshake                     Payload
// request   start & !busy                 req_func, req_entry_index, req_value
// response  rsp_valid (one-cycle strobe)  rsp_ceiling_value/found, rsp_floor_value/found
// csr       csr_valid & csr_ready         csr_entry_count
//
// A load request writes one table entry at its accept edge and leaves busy low.
// A query runs a ceiling search, then a floor search, through one registered read
// port, in rounds of a bounds check, a lo, a hi and a mid probe: at most
// clog2(TABLE_DEPTH) full rounds and a last partial round per search, then a done
// state; busy ends sooner on an early hit, and the response strobe shows in the
// first cycle busy is low. Synchronous reset clears the entry count and idles the
// search; table contents stay. The receiver cannot stall.

module sorted_floor_ceiling_search
   import sfcs_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_func,
   input  wire logic         [3:0] req_entry_index,
   input  wire logic signed [31:0] req_value,
   // response
   output logic                    rsp_valid,
   output logic signed      [31:0] rsp_ceiling_value,
   output logic                    rsp_ceiling_found,
   output logic signed      [31:0] rsp_floor_value,
   output logic                    rsp_floor_found,
   // entry count register
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic         [4:0] csr_entry_count
);

   cmd_type  cmd;
   stat_type stat;

   // the count register takes a write in any cycle
   assign csr_ready = 1'b1;

   // sequence the probes of both searches
   sfcs_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .busy     (busy),
      .cmd      (cmd),
      .stat     (stat)
   );

   // table, search bounds, compare and result registers
   sfcs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_entry_index   (req_entry_index),
      .req_value         (req_value),
      .csr_valid         (csr_valid),
      .csr_entry_count   (csr_entry_count),
      .rsp_valid         (rsp_valid),
      .rsp_ceiling_value (rsp_ceiling_value),
      .rsp_ceiling_found (rsp_ceiling_found),
      .rsp_floor_value   (rsp_floor_value),
      .rsp_floor_found   (rsp_floor_found)
   );

   // a response strobe is never raised back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // an accepted query holds the block busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_QUERY) |=> busy)
      else $error("query accepted without going busy");

   // a load finishes in its accept cycle and raises no response
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_LOAD) |=> (!busy && !rsp_valid))
      else $error("load request caused busy or a response");

   // a side that found nothing reports zero
   a_zero_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (!rsp_ceiling_found || !rsp_floor_found)) |->
      ((rsp_ceiling_found || rsp_ceiling_value == 32'sd0) &&
       (rsp_floor_found || rsp_floor_value == 32'sd0)))
      else $error("missing floor or ceiling with nonzero value");

endmodule

`default_nettype wire

// ----- rtl/sfcs_datapath.sv -----
`default_nettype none

module sfcs_datapath
   import sfcs_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output stat_type                stat,
   input  wire logic         [3:0] req_entry_index,
   input  wire logic signed [31:0] req_value,
   input  wire logic               csr_valid,
   input  wire logic         [4:0] csr_entry_count,
   output logic                    rsp_valid,
   output logic signed      [31:0] rsp_ceiling_value,
   output logic                    rsp_ceiling_found,
   output logic signed      [31:0] rsp_floor_value,
   output logic                    rsp_floor_found
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int IW = AW + 2;

   logic signed [31:0] table_mem [TABLE_DEPTH];
   logic signed [31:0] rd_data_ff;
   logic        [AW-1:0] rd_addr;

   logic [4:0] count_ff;

   logic signed [31:0] x_ff;
   logic signed [IW-1:0] lo_ff, lo_in;
   logic signed [IW-1:0] hi_ff, hi_in;
   logic signed [IW-1:0] top_ff;
   logic signed [IW-1:0] top_in;
   logic signed [IW:0]   mid_sum;
   logic signed [IW-1:0] mid;
   logic [31:0] count_wide;
   logic [31:0] used_wide;

   logic signed [31:0] ceil_val_ff, floor_val_ff;
   logic ceil_found_ff, floor_found_ff;
   logic rsp_valid_ff;
   logic signed [31:0] rsp_ceil_ff, rsp_floor_ff;
   logic rsp_cf_ff, rsp_ff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 5'd0;
      end else if (csr_valid) begin
         count_ff <= csr_entry_count;
      end
   end

   // saturate the count to the table depth
   always_comb begin
      count_wide = 32'(count_ff);
      if (count_wide > 32'(TABLE_DEPTH)) begin
         used_wide = 32'(TABLE_DEPTH);
      end else begin
         used_wide = count_wide;
      end
      top_in = IW'(used_wide - 32'd1);
   end

   assign mid_sum = {lo_ff[IW-1], lo_ff} + {hi_ff[IW-1], hi_ff};
   assign mid     = mid_sum[IW:1];

   always_comb begin
      unique case (cmd.rd_sel)
         SEL_LO:  rd_addr = lo_ff[AW-1:0];
         SEL_HI:  rd_addr = hi_ff[AW-1:0];
         SEL_MID: rd_addr = mid[AW-1:0];
         default: rd_addr = lo_ff[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.write && (32'(req_entry_index) < 32'(TABLE_DEPTH))) begin
         table_mem[AW'(req_entry_index)] <= req_value;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      priority if (cmd.init) begin
         lo_in = '0;
         hi_in = top_in;
      end else if (cmd.reinit) begin
         lo_in = '0;
         hi_in = top_ff;
      end else begin
         if (cmd.lo_mid_inc) lo_in = mid + IW'(1);
         if (cmd.lo_mid)     lo_in = mid;
         if (cmd.hi_mid)     hi_in = mid;
         if (cmd.hi_mid_dec) hi_in = mid - IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.init) begin
         x_ff   <= req_value;
         top_ff <= top_in;
      end
      if (cmd.ceil_set) ceil_val_ff <= rd_data_ff;
      if (cmd.floor_take || cmd.floor_set) floor_val_ff <= rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ceil_found_ff  <= 1'b0;
         floor_found_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.init) begin
            ceil_found_ff  <= 1'b0;
            floor_found_ff <= 1'b0;
         end else begin
            if (cmd.ceil_set) ceil_found_ff <= 1'b1;
            if (cmd.floor_set || cmd.floor_keep) floor_found_ff <= 1'b1;
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   // drop the value of a side that found nothing
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ceil_ff  <= ceil_found_ff ? ceil_val_ff : 32'sd0;
         rsp_cf_ff    <= ceil_found_ff;
         rsp_floor_ff <= floor_found_ff ? floor_val_ff : 32'sd0;
         rsp_ff_ff    <= floor_found_ff;
      end
   end

   assign stat.empty     = hi_ff < lo_ff;
   assign stat.x_lt_d    = x_ff < rd_data_ff;
   assign stat.x_eq_d    = x_ff == rd_data_ff;
   assign stat.mid_is_lo = mid == lo_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ceiling_value = rsp_ceil_ff;
   assign rsp_ceiling_found = rsp_cf_ff;
   assign rsp_floor_value   = rsp_floor_ff;
   assign rsp_floor_found   = rsp_ff_ff;

endmodule

`default_nettype wire

// ----- rtl/sfcs_controller.sv -----
`default_nettype none

module sfcs_controller
   import sfcs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire logic     req_func,
   output logic          busy,
   output cmd_type       cmd,
   input  wire stat_type stat
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_C_CHK = 4'd1;
   localparam logic [3:0] ST_C_LO  = 4'd2;
   localparam logic [3:0] ST_C_HI  = 4'd3;
   localparam logic [3:0] ST_C_MID = 4'd4;
   localparam logic [3:0] ST_F_CHK = 4'd5;
   localparam logic [3:0] ST_F_LO  = 4'd6;
   localparam logic [3:0] ST_F_HI  = 4'd7;
   localparam logic [3:0] ST_F_MID = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.rd_sel = SEL_LO;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_func == FUNC_QUERY) begin
                  cmd.init = 1'b1;
                  state_in = ST_C_CHK;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_C_CHK: begin
            cmd.rd_sel = SEL_LO;
            if (stat.empty) begin
               cmd.reinit = 1'b1;
               state_in   = ST_F_CHK;
            end else begin
               state_in = ST_C_LO;
            end
         end
         ST_C_LO: begin
            cmd.rd_sel = SEL_HI;
            if (stat.x_lt_d || stat.x_eq_d) begin
               cmd.ceil_set = 1'b1;
               cmd.reinit   = 1'b1;
               state_in     = ST_F_CHK;
            end else begin
               state_in = ST_C_HI;
            end
         end
         ST_C_HI: begin
            cmd.rd_sel = SEL_MID;
            if (!(stat.x_lt_d || stat.x_eq_d)) begin
               cmd.reinit = 1'b1;
               state_in   = ST_F_CHK;
            end else begin
               state_in = ST_C_MID;
            end
         end
         ST_C_MID: begin
            if (stat.x_eq_d) begin
               cmd.ceil_set = 1'b1;
               cmd.reinit   = 1'b1;
               state_in     = ST_F_CHK;
            end else if (!stat.x_lt_d) begin
               cmd.lo_mid_inc = 1'b1;
               state_in       = ST_C_CHK;
            end else begin
               cmd.hi_mid = 1'b1;
               state_in   = ST_C_CHK;
            end
         end
         ST_F_CHK: begin
            cmd.rd_sel = SEL_LO;
            if (stat.empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_F_LO;
            end
         end
         ST_F_LO: begin
            cmd.rd_sel = SEL_HI;
            if (stat.x_lt_d) begin
               state_in = ST_DONE;
            end else begin
               // hold the entry at lo in case the midpoint lands on it
               cmd.floor_take = 1'b1;
               state_in       = ST_F_HI;
            end
         end
         ST_F_HI: begin
            cmd.rd_sel = SEL_MID;
            if (!stat.x_lt_d) begin
               cmd.floor_set = 1'b1;
               state_in      = ST_DONE;
            end else if (stat.mid_is_lo) begin
               cmd.floor_keep = 1'b1;
               state_in       = ST_DONE;
            end else begin
               state_in = ST_F_MID;
            end
         end
         ST_F_MID: begin
            if (stat.x_eq_d) begin
               cmd.floor_set = 1'b1;
               state_in      = ST_DONE;
            end else if (!stat.x_lt_d) begin
               cmd.lo_mid = 1'b1;
               state_in   = ST_F_CHK;
            end else begin
               cmd.hi_mid_dec = 1'b1;
               state_in       = ST_F_CHK;
            end
         end
         ST_DONE: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;

endmodule

`default_nettype wire
